>>> rtl/ppme_pkg.sv
// Shared types, constants and the arctangent table of the pilot phase estimator.
`timescale 1ns / 1ps
package ppme_pkg;

    localparam int BAU_W       = 16;
    localparam int PSUM_W      = 36;
    localparam int PHSUM_W     = 21;
    localparam int MEAN_W      = 17;
    localparam int RMS_W       = 16;
    localparam int OUT_TDATA_W = 40;

    // Selects which quantity the shared divider works on.
    typedef enum logic [1:0] {
        DIV_MEAN1,
        DIV_MEAN2,
        DIV_POWER
    } div_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     cordic_step;
        logic     store;
        logic     div_start;
        div_sel_t div_sel;
        logic     pass_step;
        logic     sqrt_start;
        logic     out_load;
    } ppme_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cordic_last;
        logic last_pilot;
        logic div_busy;
        logic pass_last;
        logic sqrt_busy;
        logic out_full;
    } ppme_status_t;

    // Rounded atan(2^-i) in binary angle units; zero past the table.
    function automatic logic signed [BAU_W-1:0] atan_bau(input int unsigned i);
        logic signed [BAU_W-1:0] a;
        case (i)
            0:       a = 16'sd8192;
            1:       a = 16'sd4836;
            2:       a = 16'sd2555;
            3:       a = 16'sd1297;
            4:       a = 16'sd651;
            5:       a = 16'sd326;
            6:       a = 16'sd163;
            7:       a = 16'sd81;
            8:       a = 16'sd41;
            9:       a = 16'sd20;
            10:      a = 16'sd10;
            11:      a = 16'sd5;
            12:      a = 16'sd3;
            13:      a = 16'sd1;
            14:      a = 16'sd1;
            default: a = 16'sd0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/ppme_ctrl.sv
// Controller state machine of the pilot phase estimator.
`timescale 1ns / 1ps
module ppme_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  ppme_pkg::ppme_status_t status,
    output ppme_pkg::ppme_cmd_t    cmd
);
    import ppme_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_STORE,
        ST_DIV1,
        ST_WAIT1,
        ST_PASS,
        ST_DIV2,
        ST_WAIT2,
        ST_DIVP,
        ST_WAITP,
        ST_SQRT,
        ST_WAITS,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_MEAN1;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                if (status.cordic_last)
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = status.last_pilot ? ST_DIV1 : ST_IDLE;
            end
            ST_DIV1:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MEAN1;
                state_next    = ST_WAIT1;
            end
            ST_WAIT1:
                if (!status.div_busy)
                    state_next = ST_PASS;
            ST_PASS:
            begin
                cmd.pass_step = 1'b1;
                if (status.pass_last)
                    state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MEAN2;
                state_next    = ST_WAIT2;
            end
            ST_WAIT2:
                if (!status.div_busy)
                    state_next = ST_DIVP;
            ST_DIVP:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_POWER;
                state_next    = ST_WAITP;
            end
            ST_WAITP:
                if (!status.div_busy)
                    state_next = ST_SQRT;
            ST_SQRT:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_WAITS;
            end
            ST_WAITS:
                if (!status.sqrt_busy)
                    state_next = ST_OUT;
            ST_OUT:
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/ppme_dp.sv
// Datapath of the pilot phase estimator: CORDIC, pilot store, sums, divider, square root.
`timescale 1ns / 1ps
module ppme_dp #(
    parameter int PILOT_COUNT  = 12,
    parameter int SAMPLE_WIDTH = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ppme_pkg::ppme_cmd_t                    cmd,
    output ppme_pkg::ppme_status_t                 status,
    input  logic signed [SAMPLE_WIDTH-1:0]         sample_re,
    input  logic signed [SAMPLE_WIDTH-1:0]         sample_im,
    input  logic signed [ppme_pkg::BAU_W-1:0]      ref_phase,
    input  logic                                   m_tready,
    output logic                                   m_tvalid,
    output logic                                   m_tlast,
    output logic [ppme_pkg::OUT_TDATA_W-1:0]       m_tdata
);
    import ppme_pkg::*;

    localparam int XW   = SAMPLE_WIDTH + 10;
    localparam int SQW  = 2 * SAMPLE_WIDTH;
    localparam int ACW  = (SQW + 1 > PSUM_W) ? SQW + 2 : PSUM_W + 1;
    localparam int IW   = $clog2(PILOT_COUNT);
    localparam int CSW  = $clog2(CORDIC_STEPS);
    localparam int S2W  = 19 + $clog2(PILOT_COUNT);
    localparam int DMW  = PSUM_W + 1;
    localparam int DSW  = DMW + 1;
    localparam int CHW  = 16;
    localparam int DCH  = (DMW + CHW - 1) / CHW;
    localparam int AW   = DCH * CHW;
    localparam int RS   = DMW + 7;
    localparam int PRW  = AW + RS;
    localparam int DCW  = $clog2(DCH + 2);
    localparam int SQ_STEPS = PSUM_W / 2;
    localparam int SCW  = $clog2(SQ_STEPS);

    // Reciprocals of the two constant divisors, rounded up, exact for the dividend range.
    localparam longint unsigned REC_PAIR =
        ((64'd1 << RS) + 64'(2 * PILOT_COUNT) - 64'd1) / 64'(2 * PILOT_COUNT);
    localparam longint unsigned REC_ONE =
        ((64'd1 << RS) + 64'(PILOT_COUNT) - 64'd1) / 64'(PILOT_COUNT);

    // Pilot registers and CORDIC state.
    logic signed [SAMPLE_WIDTH-1:0] re_reg, im_reg;
    logic signed [BAU_W-1:0]        ref_reg;
    logic                           zero_reg;
    logic signed [XW-1:0]           x_reg, y_reg;
    logic signed [BAU_W-1:0]        z_reg;
    logic [CSW-1:0]                 cstep_reg;
    logic [SQW-1:0]                 sq_re_reg, sq_im_reg;

    // Run state.
    logic signed [BAU_W-1:0]        store_mem [PILOT_COUNT];
    logic signed [BAU_W-1:0]        store_rd_reg;
    logic [IW-1:0]                  cnt_reg, pass_reg, pass_next;
    logic signed [PHSUM_W-1:0]      phase_sum_reg;
    logic [PSUM_W-1:0]              power_sum_reg;
    logic signed [S2W-1:0]          sum2_reg;
    logic signed [MEAN_W-1:0]       mean1_reg, mean2_reg;
    logic [PSUM_W-1:0]              pmean_reg;

    // Divider and square root state.
    logic                           div_busy_reg, div_neg_reg;
    div_sel_t                       div_sel_reg;
    logic [DMW-1:0]                 div_mag_reg;
    logic [AW-1:0]                  div_sh_reg;
    logic [PRW-1:0]                 div_acc_reg;
    logic [DMW-1:0]                 div_quo_reg;
    logic [DCW-1:0]                 div_cnt_reg;
    logic                           sq_busy_reg;
    logic [PSUM_W-1:0]              sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [SCW-1:0]                 sq_cnt_reg;

    // Output register.
    logic                           out_valid_reg;
    logic signed [MEAN_W-1:0]       out_mean_reg;
    logic [RMS_W-1:0]               out_rms_reg;

    // Combinational helpers.
    logic signed [XW-1:0]    x0, y0, xa, ya, xsh, ysh;
    logic signed [BAU_W-1:0] za, z_fin, ph;
    logic signed [SQW-1:0]   p_re, p_im;
    logic [ACW-1:0]          pw_acc;
    logic signed [18:0]      pv, pd, pv_adj;
    logic signed [DSW-1:0]   div_a, div_mag, div_q, div_res;
    logic [RS-1:0]           div_rec;
    logic [CHW+RS-1:0]       div_pp;
    logic [DMW-1:0]          div_back;
    logic [PSUM_W-1:0]       sq_rb;

    // Quarter-turn pre-rotation into the right half plane.
    always_comb
    begin
        x0 = XW'(sample_re) <<< 8;
        y0 = XW'(sample_im) <<< 8;
        xa = x0;
        ya = y0;
        za = '0;
        if (x0 < 0)
        begin
            if (y0 >= 0)
            begin
                xa = y0;
                ya = -x0;
                za = 16'sd16384;
            end
            else
            begin
                xa = -y0;
                ya = x0;
                za = -16'sd16384;
            end
        end
    end

    // One vectoring step per cycle.
    assign xsh   = x_reg >>> cstep_reg;
    assign ysh   = y_reg >>> cstep_reg;
    assign z_fin = zero_reg ? '0 : z_reg;
    assign ph    = z_fin - ref_reg;
    assign p_re  = re_reg * re_reg;
    assign p_im  = im_reg * im_reg;
    assign pw_acc = ACW'(power_sum_reg) + ACW'(sq_re_reg) + ACW'(sq_im_reg);

    // Re-wrap pass address; the store is read in the cycle before its use.
    always_comb
    begin
        pass_next = pass_reg;
        if (cmd.pass_step)
            pass_next = status.pass_last ? '0 : pass_reg + 1'b1;
    end

    // Second pass: re-wrap one stored phase around the first mean.
    always_comb
    begin
        pv     = 19'(store_rd_reg);
        pd     = pv - 19'(mean1_reg);
        pv_adj = pv;
        if (pd < -19'sd32768)
            pv_adj = pv + 19'sd65536;
        else if (pd > 19'sd32768)
            pv_adj = pv - 19'sd65536;
    end

    // Divider operand selection and multiplication by the reciprocal of the divisor.
    always_comb
    begin
        div_a = DSW'({1'b0, power_sum_reg});
        case (cmd.div_sel)
            DIV_MEAN1:
                div_a = (DSW'(phase_sum_reg) <<< 1) + DSW'(PILOT_COUNT);
            DIV_MEAN2:
                div_a = (DSW'(sum2_reg) <<< 1) + DSW'(PILOT_COUNT);
            default:
                div_a = DSW'({1'b0, power_sum_reg});
        endcase
        div_mag  = div_a[DSW-1] ? -div_a : div_a;
        div_rec  = (div_sel_reg == DIV_POWER) ? RS'(REC_ONE) : RS'(REC_PAIR);
        div_pp   = (CHW+RS)'(div_sh_reg[AW-1 -: CHW]) * (CHW+RS)'(div_rec);
        div_back = (div_sel_reg == DIV_POWER) ? div_quo_reg * DMW'(PILOT_COUNT)
                                              : div_quo_reg * DMW'(2 * PILOT_COUNT);
        div_q    = DSW'(div_quo_reg);
        div_res  = div_neg_reg ? (-div_q - DSW'(div_back != div_mag_reg)) : div_q;
    end

    assign sq_rb = sq_r_reg + sq_bit_reg;

    // Control and accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cstep_reg     <= '0;
            cnt_reg       <= '0;
            pass_reg      <= '0;
            phase_sum_reg <= '0;
            power_sum_reg <= '0;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            sq_busy_reg   <= 1'b0;
            sq_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cordic_step)
                cstep_reg <= status.cordic_last ? '0 : cstep_reg + 1'b1;

            // Store one wrapped phase and add its power.
            if (cmd.store)
            begin
                cnt_reg       <= status.last_pilot ? '0 : cnt_reg + 1'b1;
                phase_sum_reg <= phase_sum_reg + PHSUM_W'(ph);
                if (pw_acc > ACW'({PSUM_W{1'b1}}))
                    power_sum_reg <= '1;
                else
                    power_sum_reg <= pw_acc[PSUM_W-1:0];
            end

            pass_reg <= pass_next;

            // Divider sequencing: chunk products, quotient, result.
            if (cmd.div_start)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end
            else if (div_busy_reg)
            begin
                if (div_cnt_reg == DCW'(DCH + 1))
                    div_busy_reg <= 1'b0;
                else
                    div_cnt_reg <= div_cnt_reg + 1'b1;
            end

            // Square root sequencing.
            if (cmd.sqrt_start)
            begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg  <= '0;
            end
            else if (sq_busy_reg)
            begin
                if (sq_cnt_reg == SCW'(SQ_STEPS - 1))
                    sq_busy_reg <= 1'b0;
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
            end

            // Output register and end of run.
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                phase_sum_reg <= '0;
                power_sum_reg <= '0;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            re_reg   <= sample_re;
            im_reg   <= sample_im;
            ref_reg  <= ref_phase;
            zero_reg <= (sample_re == '0) && (sample_im == '0);
            x_reg    <= xa;
            y_reg    <= ya;
            z_reg    <= za;
        end
        else if (cmd.cordic_step)
        begin
            sq_re_reg <= SQW'(p_re);
            sq_im_reg <= SQW'(p_im);
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + ysh;
                y_reg <= y_reg - xsh;
                z_reg <= z_reg + atan_bau(32'(cstep_reg));
            end
            else
            begin
                x_reg <= x_reg - ysh;
                y_reg <= y_reg + xsh;
                z_reg <= z_reg - atan_bau(32'(cstep_reg));
            end
        end

        if (cmd.store)
            store_mem[cnt_reg] <= ph;
        store_rd_reg <= store_mem[pass_next];

        if (cmd.div_start && cmd.div_sel == DIV_MEAN1)
            sum2_reg <= '0;
        else if (cmd.pass_step)
            sum2_reg <= sum2_reg + S2W'(pv_adj);

        // Divider datapath, most significant dividend chunk first.
        if (cmd.div_start)
        begin
            div_sel_reg <= cmd.div_sel;
            div_neg_reg <= div_a[DSW-1];
            div_mag_reg <= div_mag[DMW-1:0];
            div_sh_reg  <= AW'(div_mag[DMW-1:0]);
            div_acc_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            if (div_cnt_reg < DCW'(DCH))
            begin
                div_acc_reg <= (div_acc_reg << CHW) + PRW'(div_pp);
                div_sh_reg  <= div_sh_reg << CHW;
            end
            else if (div_cnt_reg == DCW'(DCH))
                div_quo_reg <= div_acc_reg[RS +: DMW];
            else
            begin
                case (div_sel_reg)
                    DIV_MEAN1: mean1_reg <= div_res[MEAN_W-1:0];
                    DIV_MEAN2: mean2_reg <= div_res[MEAN_W-1:0];
                    default:   pmean_reg <= div_res[PSUM_W-1:0];
                endcase
            end
        end

        // Square root datapath, one result bit per power of four.
        if (cmd.sqrt_start)
        begin
            sq_v_reg   <= pmean_reg;
            sq_r_reg   <= '0;
            sq_bit_reg <= PSUM_W'(1) << (PSUM_W - 2);
        end
        else if (sq_busy_reg)
        begin
            if (sq_v_reg >= sq_rb)
            begin
                sq_v_reg <= sq_v_reg - sq_rb;
                sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
            end
            else
                sq_r_reg <= sq_r_reg >> 1;
            sq_bit_reg <= sq_bit_reg >> 2;
        end

        if (cmd.out_load)
        begin
            out_mean_reg <= mean2_reg;
            out_rms_reg  <= sq_r_reg[RMS_W-1:0];
        end
    end

    assign status.cordic_last = (cstep_reg == CSW'(CORDIC_STEPS - 1));
    assign status.last_pilot  = (cnt_reg == IW'(PILOT_COUNT - 1));
    assign status.div_busy    = div_busy_reg;
    assign status.pass_last   = (pass_reg == IW'(PILOT_COUNT - 1));
    assign status.sqrt_busy   = sq_busy_reg;
    assign status.out_full    = out_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = 1'b1;
    assign m_tdata  = {(OUT_TDATA_W - MEAN_W - RMS_W)'(0), out_rms_reg, out_mean_reg};

endmodule

>>> rtl/pilot_phase_magnitude_estimator.sv
// Top level of the pilot phase and magnitude estimator.
//
// Pilots arrive on the slave stream, one transfer per pilot carrying the
// received I/Q sample and its known reference phase. Each pilot is taken
// from the stream, then passes through the CORDIC_STEPS atan2 iterations of
// the single shared CORDIC unit and a step that stores the phase and adds
// the power. s_tready is high only while the block waits for a pilot.
// After the last pilot of a run of PILOT_COUNT the block runs three passes of
// a divider that multiplies by the constant reciprocal in three chunks, a
// re-wrap pass over the PILOT_COUNT stored phases and an 18-step square
// root, then places one result on the master stream with tlast set.
// The result waits in an output register; pilots of the next run are taken
// meanwhile, and only the end of that next run waits for m_tready.
// Reset clears the phase and power sums, counters and output valid; the
// phase store is always written within a run before it is read.
`timescale 1ns / 1ps
module pilot_phase_magnitude_estimator #(
    parameter int PILOT_COUNT  = 12,
    parameter int SAMPLE_WIDTH = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0: sample_re, sample_im, ref_phase, zero fill.
    input  logic [((2*SAMPLE_WIDTH+16+7)/8)*8-1:0]  s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // Fields from bit 0: mean_phase (17), rms_magnitude (16), zero fill.
    output logic [ppme_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // Marks the result of a run (run_done).
    output logic                                   m_tlast
);
    import ppme_pkg::*;

    ppme_cmd_t    cmd;
    ppme_status_t status;

    ppme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ppme_dp #(
        .PILOT_COUNT  (PILOT_COUNT),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample_re (s_tdata[SAMPLE_WIDTH-1:0]),
        .sample_im (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .ref_phase (s_tdata[2*SAMPLE_WIDTH+BAU_W-1:2*SAMPLE_WIDTH]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tlast   (m_tlast),
        .m_tdata   (m_tdata)
    );

endmodule

>>> rtl/ppme_checker.sv
// Port-level assertions for the pilot phase estimator and their bind.
`timescale 1ns / 1ps
module ppme_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ppme_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                              m_tlast
);
    import ppme_pkg::*;

    // A stalled result holds its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Every result closes a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tlast)
        else $error("result without tlast");

    // The block drops s_tready at the start of the CORDIC steps after a pilot transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("pilot taken during CORDIC");

    // A new result never appears just after a pilot transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result raised right after pilot");

endmodule

bind pilot_phase_magnitude_estimator ppme_checker u_ppme_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
